/* hdl/protected_zone_table_macros.svh */
// Assertion macros shared by the protected zone table RTL.
// No dependencies; included inside module bodies that use clk and rst.
`ifndef PROTECTED_ZONE_TABLE_MACROS_SVH
`define PROTECTED_ZONE_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PZT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pzt assertion failed");

// next-cycle implication, disabled during reset
`define PZT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pzt assertion failed");

`endif

/* hdl/pzt_pkg.sv */
// Package for the protected zone table: table size, command and status codes,
// request, entry and compare-result types. No dependencies.
`default_nettype none

package pzt_pkg;

  localparam int ZONES = 8;
  localparam int IDX_W = (ZONES > 1) ? $clog2(ZONES) : 1;

  localparam logic [1:0] CMD_PROTECT   = 2'd0;
  localparam logic [1:0] CMD_UNPROTECT = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] space_id;
    logic [31:0] address;
    logic [31:0] zone_size;
  } req_t;

  typedef struct packed {
    logic        used;
    logic [15:0] space_id;
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  typedef struct packed {
    logic free;   // entry unused
    logic exact;  // used, same space, start and length
    logic hit;    // used, same space, address inside the zone
  } cmp_t;

endpackage

`default_nettype wire

/* hdl/pzt_cmp.sv */
// Shared compare unit: checks one table entry against the current request.
// Depends on pzt_pkg.
`default_nettype none

module pzt_cmp (
  input  pzt_pkg::entry_t ent,
  input  pzt_pkg::req_t   req,
  output pzt_pkg::cmp_t   res
);
  import pzt_pkg::*;

  logic        same_space;
  logic [32:0] zone_end;

  assign same_space = ent.used && (ent.space_id == req.space_id);
  // end bound in 33 bits so a zone never wraps
  assign zone_end   = {1'b0, ent.start} + {1'b0, ent.length};

  assign res.free  = !ent.used;
  assign res.exact = same_space && (ent.start == req.address) &&
                     (ent.length == req.zone_size);
  assign res.hit   = same_space && (req.address >= ent.start) &&
                     ({1'b0, req.address} < zone_end);

endmodule

`default_nettype wire

/* hdl/protected_zone_table.sv */
// After a request is accepted, the compare unit checks one table entry per
// cycle and the scan stops at the first free/matching entry or the last entry.
// A new request is taken only after the result is registered: the single compare
// unit walks the table one entry a cycle; s_tready is low while a scan runs.
// Reset (rst, synchronous) clears all used flags together; no clearing pass.
`default_nettype none

module protected_zone_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // space_id[15:0], address[47:16], zone_size[79:48]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // status[1:0], is_protected[2], zero pad[7:3]
);
  import pzt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state;
  logic [IDX_W-1:0] idx;
  req_t             req;

  logic [ZONES-1:0] used;
  logic [15:0]      ent_space [ZONES];
  logic [31:0]      ent_start [ZONES];
  logic [31:0]      ent_len   [ZONES];

  logic [1:0] out_status;
  logic       out_prot;

  entry_t ent;
  cmp_t   cmp;
  logic   last, found, done, out_free, finish;
  logic [1:0] res_status;
  logic       res_prot;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {5'b0, out_prot, out_status};
  assign out_free = !m_tvalid || m_tready;

  assign ent = '{used: used[idx], space_id: ent_space[idx],
                 start: ent_start[idx], length: ent_len[idx]};

  pzt_cmp u_cmp (
    .ent (ent),
    .req (req),
    .res (cmp)
  );

  assign last = (idx == IDX_W'(ZONES - 1));

  always_comb begin
    found      = 1'b0;
    res_status = ST_OK;
    res_prot   = 1'b0;
    case (req.cmd)
      CMD_PROTECT: begin
        found      = cmp.free;
        res_status = found ? ST_OK : ST_FULL;
      end
      CMD_UNPROTECT: begin
        found      = cmp.exact;
        res_status = found ? ST_OK : ST_NOT_FOUND;
      end
      CMD_QUERY: begin
        found    = cmp.hit;
        res_prot = found;
      end
      default: begin
        found = 1'b1;  // unused command: no-op, ok
      end
    endcase
    done = found || last;
  end

  // stalls on the current entry while the output register is occupied
  assign finish = (state == S_SCAN) && done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !finish) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req   <= '{cmd: s_tuser, space_id: s_tdata[15:0],
                       address: s_tdata[47:16], zone_size: s_tdata[79:48]};
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (finish) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_prot   <= res_prot;
            state      <= S_IDLE;
            if (found && req.cmd == CMD_PROTECT) begin
              used[idx] <= 1'b1;
            end
            if (found && req.cmd == CMD_UNPROTECT) begin
              used[idx] <= 1'b0;
            end
          end else if (!done) begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // entry payload: no reset, only read while the used flag is set
  always_ff @(posedge clk) begin
    if (finish && found && req.cmd == CMD_PROTECT) begin
      ent_space[idx] <= req.space_id;
      ent_start[idx] <= req.address;
      ent_len[idx]   <= req.zone_size;
    end
  end

`include "protected_zone_table_macros.svh"

  `PZT_ASSERT_NEXT(a_protect_marks_used, finish && found && req.cmd == CMD_PROTECT, used[$past(idx)])
  `PZT_ASSERT_NEXT(a_unprotect_clears, finish && found && req.cmd == CMD_UNPROTECT, !used[$past(idx)])
  `PZT_ASSERT_IMPL(a_full_only_when_full, finish && res_status == ST_FULL, &used)
  `PZT_ASSERT_IMPL(a_prot_only_on_query, finish && res_prot, req.cmd == CMD_QUERY && res_status == ST_OK)

endmodule

`default_nettype wire
